// ===== design/apc_pkg.sv =====
// Shared types and constants for the arithmetic pixel compositor.
package apc_pkg;

    localparam int COEF_W      = 16;
    localparam int DIV_IN_W    = 33;
    localparam int DIV_OUT_W   = 25;
    localparam int SUM_W       = 27;
    localparam int PIPE_DEPTH  = 16;
    localparam int RECIP_SHIFT = 39;
    localparam logic [31:0] RECIP_255 = 32'h8080_8081;

    typedef enum logic [2:0] {
        REG_PRODUCT = 3'd0,
        REG_FIRST   = 3'd1,
        REG_SECOND  = 3'd2,
        REG_OFFSET  = 3'd3
    } reg_index_t;

    typedef struct packed {
        logic signed [COEF_W-1:0] product;
        logic signed [COEF_W-1:0] first;
        logic signed [COEF_W-1:0] second;
        logic signed [COEF_W-1:0] offset;
    } coef_t;

endpackage

// ===== design/apc_div255.sv =====
// Three-stage signed divide by 255, truncating toward zero.
module apc_div255
    import apc_pkg::*;
(
    input  logic                        clk,
    input  logic signed [DIV_IN_W-1:0]  num,
    output logic signed [DIV_OUT_W-1:0] quot
);

    logic [DIV_IN_W-1:0]         abs_full;
    logic                        neg_reg;
    logic [31:0]                 mag_reg;
    logic                        neg_b_reg;
    logic [63:0]                 prod_reg;
    logic [63:0]                 prod_next;
    logic signed [DIV_OUT_W-1:0] qmag;
    logic signed [DIV_OUT_W-1:0] quot_next;
    logic signed [DIV_OUT_W-1:0] quot_reg;

    assign abs_full  = num[DIV_IN_W-1] ? DIV_IN_W'(-num) : DIV_IN_W'(num);
    // Reciprocal multiply is exact for any 32-bit magnitude
    assign prod_next = mag_reg * RECIP_255;
    assign qmag      = $signed(prod_reg[63:RECIP_SHIFT]);
    assign quot_next = neg_b_reg ? -qmag : qmag;

    always_ff @(posedge clk)
    begin
        neg_reg   <= num[DIV_IN_W-1];
        mag_reg   <= abs_full[31:0];
        neg_b_reg <= neg_reg;
        prod_reg  <= prod_next;
        quot_reg  <= quot_next;
    end

    assign quot = quot_reg;

endmodule

// ===== design/apc_lane.sv =====
// Weighted sum of one channel pair: k1*ca*cb/255 + k2*ca + k3*cb.
module apc_lane
    import apc_pkg::*;
(
    input  logic                    clk,
    input  coef_t                   coef,
    input  logic [7:0]              ca,
    input  logic [7:0]              cb,
    output logic signed [SUM_W-1:0] sum
);

    logic [15:0]                 prod_reg;
    logic signed [24:0]          ta_next;
    logic signed [24:0]          tb_next;
    logic signed [24:0]          ta_reg;
    logic signed [24:0]          tb_reg;
    logic signed [DIV_IN_W-1:0]  kp_next;
    logic signed [DIV_IN_W-1:0]  kp_reg;
    logic signed [SUM_W-1:0]     lin_reg;
    logic signed [SUM_W-1:0]     lin_dly_reg [3];
    logic signed [DIV_OUT_W-1:0] kp_quot;
    logic signed [SUM_W-1:0]     sum_reg;

    assign ta_next = coef.first * $signed({1'b0, ca});
    assign tb_next = coef.second * $signed({1'b0, cb});
    assign kp_next = coef.product * $signed({1'b0, prod_reg});

    always_ff @(posedge clk)
    begin
        prod_reg       <= ca * cb;
        ta_reg         <= ta_next;
        tb_reg         <= tb_next;
        kp_reg         <= kp_next;
        lin_reg        <= SUM_W'(ta_reg) + SUM_W'(tb_reg);
        // hold the linear terms while the product term is divided
        lin_dly_reg[0] <= lin_reg;
        lin_dly_reg[1] <= lin_dly_reg[0];
        lin_dly_reg[2] <= lin_dly_reg[1];
        sum_reg        <= SUM_W'(kp_quot) + lin_dly_reg[2];
    end

    apc_div255 u_div
    (
        .clk  (clk),
        .num  (kp_reg),
        .quot (kp_quot)
    );

    assign sum = sum_reg;

endmodule

// ===== design/arithmetic_pixel_composite.sv =====
// Top level of the arithmetic pixel compositor.
// Takes one pixel pair on every clock in which start is high; busy never rises,
// so a new request may follow in the very next cycle. Each result is marked
// by done for one cycle and comes back in request order. The pipeline holds
// three chained divide-by-255 units (each a three-stage reciprocal multiply)
// plus the product, offset and clamp stages. Coefficient registers are written
// through the cfg channel, which is always ready; write them only while no
// request is in flight.
module arithmetic_pixel_composite
    import apc_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [7:0]               first_c0,
    input  logic [7:0]               first_c1,
    input  logic [7:0]               first_c2,
    input  logic [7:0]               first_alpha,
    input  logic [7:0]               second_c0,
    input  logic [7:0]               second_c1,
    input  logic [7:0]               second_c2,
    input  logic [7:0]               second_alpha,
    output logic                     done,
    output logic [7:0]               out_c0,
    output logic [7:0]               out_c1,
    output logic [7:0]               out_c2,
    output logic [7:0]               out_alpha,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [2:0]               cfg_index,
    input  logic signed [COEF_W-1:0] cfg_data
);

    coef_t                       coef_reg;
    logic [PIPE_DEPTH-1:0]       vld_reg;
    logic [PIPE_DEPTH-1:0]       vld_next;
    logic                        accept;

    logic [7:0]                  ca_in [3];
    logic [7:0]                  cb_in [3];
    logic [7:0]                  res_c [3];

    logic signed [SUM_W-1:0]     alpha_sum;
    logic signed [DIV_OUT_W-1:0] alpha_quot;
    logic [7:0]                  qr_next;
    logic [7:0]                  qr_reg;
    logic [7:0]                  qr_dly_reg [5];
    logic [7:0]                  alpha_out_reg;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign accept    = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (reg_index_t'(cfg_index))
                REG_PRODUCT: coef_reg.product <= cfg_data;
                REG_FIRST:   coef_reg.first   <= cfg_data;
                REG_SECOND:  coef_reg.second  <= cfg_data;
                REG_OFFSET:  coef_reg.offset  <= cfg_data;
                default:     ;
            endcase
        end
    end

    // advance the valid bits alongside the data
    assign vld_next = {vld_reg[PIPE_DEPTH-2:0], accept};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    assign done = vld_reg[PIPE_DEPTH-1];

    // alpha path
    apc_lane u_lane_alpha
    (
        .clk  (clk),
        .coef (coef_reg),
        .ca   (first_alpha),
        .cb   (second_alpha),
        .sum  (alpha_sum)
    );

    apc_div255 u_div_alpha
    (
        .clk  (clk),
        .num  (DIV_IN_W'(alpha_sum)),
        .quot (alpha_quot)
    );

    always_comb
    begin
        if (alpha_quot < 0)
        begin
            qr_next = 8'd0;
        end
        else if (alpha_quot > $signed(DIV_OUT_W'(255)))
        begin
            qr_next = 8'd255;
        end
        else
        begin
            qr_next = alpha_quot[7:0];
        end
    end

    always_ff @(posedge clk)
    begin
        qr_reg        <= qr_next;
        qr_dly_reg[0] <= qr_reg;
        qr_dly_reg[1] <= qr_dly_reg[0];
        qr_dly_reg[2] <= qr_dly_reg[1];
        qr_dly_reg[3] <= qr_dly_reg[2];
        qr_dly_reg[4] <= qr_dly_reg[3];
        alpha_out_reg <= qr_dly_reg[4];
    end

    assign ca_in[0] = first_c0;
    assign ca_in[1] = first_c1;
    assign ca_in[2] = first_c2;
    assign cb_in[0] = second_c0;
    assign cb_in[1] = second_c1;
    assign cb_in[2] = second_c2;

    for (genvar ch = 0; ch < 3; ch++)
    begin : g_color
        logic signed [SUM_W-1:0]     c_sum;
        logic signed [SUM_W-1:0]     sum_dly_reg [5];
        logic signed [24:0]          koff_next;
        logic signed [24:0]          koff_reg;
        logic signed [SUM_W-1:0]     tot_reg;
        logic signed [DIV_OUT_W-1:0] c_quot;
        logic [7:0]                  c_next;
        logic [7:0]                  c_reg;

        apc_lane u_lane
        (
            .clk  (clk),
            .coef (coef_reg),
            .ca   (ca_in[ch]),
            .cb   (cb_in[ch]),
            .sum  (c_sum)
        );

        assign koff_next = coef_reg.offset * $signed({1'b0, qr_reg});

        always_ff @(posedge clk)
        begin
            // hold the color sum until the result alpha is known
            sum_dly_reg[0] <= c_sum;
            sum_dly_reg[1] <= sum_dly_reg[0];
            sum_dly_reg[2] <= sum_dly_reg[1];
            sum_dly_reg[3] <= sum_dly_reg[2];
            sum_dly_reg[4] <= sum_dly_reg[3];
            koff_reg       <= koff_next;
            tot_reg        <= sum_dly_reg[4] + SUM_W'(koff_reg);
            c_reg          <= c_next;
        end

        apc_div255 u_div
        (
            .clk  (clk),
            .num  (DIV_IN_W'(tot_reg)),
            .quot (c_quot)
        );

        // clamp to 0..alpha; a zero alpha forces zero color
        always_comb
        begin
            if (c_quot < 0)
            begin
                c_next = 8'd0;
            end
            else if (c_quot > $signed({17'd0, qr_dly_reg[4]}))
            begin
                c_next = qr_dly_reg[4];
            end
            else
            begin
                c_next = c_quot[7:0];
            end
        end

        assign res_c[ch] = c_reg;
    end

    assign out_c0    = res_c[0];
    assign out_c1    = res_c[1];
    assign out_c2    = res_c[2];
    assign out_alpha = alpha_out_reg;

endmodule

// ===== tb/sv/arithmetic_pixel_composite_tb.sv =====
// Self-checking testbench for the arithmetic pixel compositor.
`timescale 1ns / 1ps

module arithmetic_pixel_composite_tb;
    import apc_pkg::*;

    localparam int COEF_REGS = 4;
    localparam longint OPAQUE = 255;
    localparam int RANDOM_PHASES = 10;
    localparam int PHASE_PIXELS = 100;
    localparam int DIRECTED_PIXELS = 6;
    localparam int REPORT_LIMIT = 10;
    localparam logic [15:0] COEF_MIN = 16'h8000;
    localparam logic [15:0] COEF_MAX = 16'h7FFF;
    localparam logic [15:0] COEF_LEGAL_MIN = 16'h8080;   // -32640
    localparam logic [15:0] COEF_LEGAL_MAX = 16'h7F80;   // 32640

    typedef struct packed {
        logic [2:0][7:0] first_c;
        logic [7:0]      first_alpha;
        logic [2:0][7:0] second_c;
        logic [7:0]      second_alpha;
    } pixel_pair_t;

    typedef struct packed {
        logic [2:0][7:0] color;
        logic [7:0]      alpha;
    } composite_t;

    typedef struct packed {
        logic [2:0]  index;
        logic [15:0] value;
    } coef_write_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [7:0]  first_c0 = '0;
    logic [7:0]  first_c1 = '0;
    logic [7:0]  first_c2 = '0;
    logic [7:0]  first_alpha = '0;
    logic [7:0]  second_c0 = '0;
    logic [7:0]  second_c1 = '0;
    logic [7:0]  second_c2 = '0;
    logic [7:0]  second_alpha = '0;
    logic        done;
    logic [7:0]  out_c0;
    logic [7:0]  out_c1;
    logic [7:0]  out_c2;
    logic [7:0]  out_alpha;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;

    pixel_pair_t pixel_queue[$];
    composite_t  composite_q[$];
    coef_write_t coef_writes[$];
    coef_t       coef_model = '0;
    pixel_pair_t cur_pixel;
    int          idle_pct = 6;
    int          pixels_pushed = 0;
    int          requests_taken = 0;
    int          results_checked = 0;
    int          fail_count = 0;
    int          settings_used = 1;
    int          writes_done = 0;
    int          ignored_writes = 0;

    arithmetic_pixel_composite dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .first_c0     (first_c0),
        .first_c1     (first_c1),
        .first_c2     (first_c2),
        .first_alpha  (first_alpha),
        .second_c0    (second_c0),
        .second_c1    (second_c1),
        .second_c2    (second_c2),
        .second_alpha (second_alpha),
        .done         (done),
        .out_c0       (out_c0),
        .out_c1       (out_c1),
        .out_c2       (out_c2),
        .out_alpha    (out_alpha),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic composite_t blend_pixel(pixel_pair_t px, coef_t k);
        longint     kp, kf, ks, ko, a, b, ca, cb, qr, cr;
        composite_t r;
        kp = $signed(k.product);
        kf = $signed(k.first);
        ks = $signed(k.second);
        ko = $signed(k.offset);
        a = px.first_alpha;
        b = px.second_alpha;
        qr = (kp * a * b / OPAQUE + kf * a + ks * b) / OPAQUE;
        if (qr > OPAQUE)
            qr = OPAQUE;
        if (qr < 0)
            qr = 0;
        r.alpha = qr[7:0];
        for (int ch = 0; ch < 3; ch++)
        begin
            ca = px.first_c[ch];
            cb = px.second_c[ch];
            cr = 0;
            // zero alpha forces black; otherwise bound colour by the new alpha
            if (qr != 0)
            begin
                cr = (kp * ca * cb / OPAQUE + kf * ca + ks * cb + ko * qr) / OPAQUE;
                if (cr > qr)
                    cr = qr;
                if (cr < 0)
                    cr = 0;
            end
            r.color[ch] = cr[7:0];
        end
        return r;
    endfunction

    function automatic pixel_pair_t make_pixel(logic [7:0] fc0, logic [7:0] fc1, logic [7:0] fc2,
                                               logic [7:0] fa, logic [7:0] sc0, logic [7:0] sc1,
                                               logic [7:0] sc2, logic [7:0] sa);
        pixel_pair_t px;
        px.first_c = {fc2, fc1, fc0};
        px.first_alpha = fa;
        px.second_c = {sc2, sc1, sc0};
        px.second_alpha = sa;
        return px;
    endfunction

    function automatic pixel_pair_t directed_pixel(int n);
        case (n)
            0: return make_pixel(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
            1: return make_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
            // colours above their alpha on both sides
            2: return make_pixel(8'hFF, 8'hC8, 8'h01, 8'h00, 8'hC8, 8'h0B, 8'h0A, 8'h0A);
            3: return make_pixel(8'h40, 8'h20, 8'h00, 8'h80, 8'hFF, 8'h80, 8'h01, 8'hFF);
            4: return make_pixel(8'hAA, 8'h55, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00);
            default: return make_pixel(8'h55, 8'h2A, 8'h01, 8'h55, 8'hAA, 8'h55, 8'h00, 8'hAA);
        endcase
    endfunction

    function automatic logic [7:0] pick_alpha();
        if ($urandom_range(9) == 0)
            return $urandom_range(1) ? 8'hFF : 8'h00;
        return 8'($urandom_range(255));
    endfunction

    function automatic pixel_pair_t random_pixel();
        pixel_pair_t px;
        bit          tidy;
        // mostly valid premultiplied data, the rest unconstrained
        tidy = ($urandom_range(9) < 7);
        px.first_alpha = pick_alpha();
        px.second_alpha = pick_alpha();
        for (int ch = 0; ch < 3; ch++)
        begin
            px.first_c[ch] = tidy ? 8'($urandom_range(px.first_alpha)) : 8'($urandom_range(255));
            px.second_c[ch] = tidy ? 8'($urandom_range(px.second_alpha)) : 8'($urandom_range(255));
        end
        return px;
    endfunction

    function automatic logic [15:0] pick_coef();
        int v;
        case ($urandom_range(3))
            0, 1: v = int'($urandom_range(510)) - 255;
            2: v = int'($urandom_range(65280)) - 32640;
            default:
            begin
                case ($urandom_range(4))
                    0: return COEF_MIN;
                    1: return COEF_MAX;
                    2: return COEF_LEGAL_MIN;
                    3: return COEF_LEGAL_MAX;
                    default: return '0;
                endcase
            end
        endcase
        return v[15:0];
    endfunction

    task automatic queue_coefs(logic [15:0] kp, logic [15:0] kf, logic [15:0] ks,
                               logic [15:0] ko);
        coef_writes.push_back('{index: REG_PRODUCT, value: kp});
        coef_writes.push_back('{index: REG_FIRST, value: kf});
        coef_writes.push_back('{index: REG_SECOND, value: ks});
        coef_writes.push_back('{index: REG_OFFSET, value: ko});
    endtask

    task automatic apply_coefs();
        coef_write_t cw;
        @(posedge clk);
        while (coef_writes.size() != 0)
        begin
            cw = coef_writes.pop_front();
            cfg_valid <= 1'b1;
            cfg_index <= cw.index;
            cfg_data <= cw.value;
            do
                @(posedge clk);
            while (!cfg_ready);
            writes_done++;
            case (cw.index)
                REG_PRODUCT: coef_model.product = cw.value;
                REG_FIRST:   coef_model.first = cw.value;
                REG_SECOND:  coef_model.second = cw.value;
                REG_OFFSET:  coef_model.offset = cw.value;
                default:     ignored_writes++;
            endcase
        end
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    task automatic drain();
        while (requests_taken != pixels_pushed || composite_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic flag(string msg);
        if (fail_count < REPORT_LIMIT)
            $display("%0t: %s", $time, msg);
        fail_count++;
    endtask

    // request driver
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
            begin
                composite_q.push_back(blend_pixel(cur_pixel, coef_model));
                requests_taken++;
            end
            if (!start || !busy)
            begin
                if (pixel_queue.size() != 0 && $urandom_range(99) >= idle_pct)
                begin
                    cur_pixel = pixel_queue.pop_front();
                    start <= 1'b1;
                    first_c0 <= cur_pixel.first_c[0];
                    first_c1 <= cur_pixel.first_c[1];
                    first_c2 <= cur_pixel.first_c[2];
                    first_alpha <= cur_pixel.first_alpha;
                    second_c0 <= cur_pixel.second_c[0];
                    second_c1 <= cur_pixel.second_c[1];
                    second_c2 <= cur_pixel.second_c[2];
                    second_alpha <= cur_pixel.second_alpha;
                end
                else
                    start <= 1'b0;
            end
        end
    end

    // result monitor
    always @(posedge clk)
    begin : result_check
        composite_t got, want;
        if (rst_n && done)
        begin
            got.color = {out_c2, out_c1, out_c0};
            got.alpha = out_alpha;
            if (composite_q.size() == 0)
                flag($sformatf("result with nothing pending: alpha %0d colour %0d %0d %0d",
                               out_alpha, out_c0, out_c1, out_c2));
            else
            begin
                want = composite_q.pop_front();
                results_checked++;
                if (got.alpha !== want.alpha)
                    flag($sformatf("out_alpha expected %0d got %0d", want.alpha, got.alpha));
                for (int ch = 0; ch < 3; ch++)
                    if (got.color[ch] !== want.color[ch])
                        flag($sformatf("out_c%0d expected %0d got %0d (alpha %0d)",
                                       ch, want.color[ch], got.color[ch], want.alpha));
            end
        end
    end

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // directed: reset coefficients first, then a few fixed settings
        for (int s = 0; s < 4; s++)
        begin
            case (s)
                1:
                begin
                    queue_coefs(16'd0, 16'd255, 16'd255, 16'd0);
                    coef_writes.push_back('{index: 3'(COEF_REGS), value: COEF_MAX});
                end
                2:
                begin
                    queue_coefs(16'd255, -16'sd255, 16'd255, 16'd64);
                    coef_writes.push_back('{index: 3'(COEF_REGS + 3), value: COEF_MIN});
                end
                3: queue_coefs(COEF_MAX, COEF_MIN, COEF_MAX, COEF_MIN);
                default: ;
            endcase
            if (s != 0)
                apply_coefs();
            for (int n = 0; n < DIRECTED_PIXELS; n++)
            begin
                pixel_queue.push_back(directed_pixel(n));
                pixels_pushed++;
            end
            drain();
        end

        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            idle_pct = (ph == 3) ? 0 : 6;
            if (ph == 0)
                queue_coefs(COEF_LEGAL_MIN, COEF_LEGAL_MAX, COEF_LEGAL_MIN, COEF_LEGAL_MAX);
            else
                queue_coefs(pick_coef(), pick_coef(), pick_coef(), pick_coef());
            if ($urandom_range(1))
                coef_writes.push_back('{index: 3'(COEF_REGS + $urandom_range(3)),
                                        value: 16'($urandom_range(65535))});
            apply_coefs();
            repeat (PHASE_PIXELS)
            begin
                pixel_queue.push_back(random_pixel());
                pixels_pushed++;
            end
            // hold new writes until the whole phase has come back
            drain();
        end

        repeat (PIPE_DEPTH + 8) @(posedge clk);
        $display("%0d pixel pairs under %0d coefficient settings, %0d results compared",
                 requests_taken, settings_used, results_checked);
        $display("%0d register writes, %0d of them to unused indexes",
                 writes_done, ignored_writes);
        if (fail_count == 0 && composite_q.size() == 0)
            $display("arithmetic_pixel_composite: match");
        else
            $display("arithmetic_pixel_composite: mismatch");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("arithmetic_pixel_composite: mismatch");
        $finish;
    end

endmodule
